@@ design/pps_pkg.sv @@
`default_nettype none

package pps_pkg;

   localparam int COORD_W = 24;
   localparam int CSR_W   = 4;

   typedef logic signed [COORD_W-1:0] coord_type;

endpackage

`default_nettype wire

@@ design/pps_round_div.sv @@
`default_nettype none

module pps_round_div #(
   parameter int SUM_W   = 29,
   parameter int MAX_CNT = 31,
   parameter int CNT_W   = 5
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic signed [SUM_W-1:0] dividend,
   input  wire logic [CNT_W-1:0]        divisor,
   output logic                         done,
   output pps_pkg::coord_type           quotient
);
   import pps_pkg::*;

   localparam int R_W = SUM_W + 1;
   localparam int P_W = SUM_W + R_W;
   localparam int Q_W = COORD_W + 1;
   localparam int E_W = ((Q_W + CNT_W) > SUM_W) ? (Q_W + CNT_W) : SUM_W;

   logic [R_W-1:0] recip [MAX_CNT+1];

   for (genvar g = 0; g <= MAX_CNT; g++) begin : g_rcp
      if (g == 0) begin : g_zero
         assign recip[g] = '0;
      end else begin : g_val
         localparam logic [R_W-1:0] RV = R_W'((64'd1 << SUM_W) / g);
         assign recip[g] = RV;
      end
   end

   logic             v0_ff, v1_ff, v2_ff;
   logic [SUM_W-1:0] mag_ff;
   logic [SUM_W-1:0] mag_in;
   logic             neg_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [R_W-1:0]   rcp_ff;
   logic [P_W-1:0]   prod_ff;
   logic [Q_W-1:0]   q0;
   logic [E_W-1:0]   back;
   logic [E_W-1:0]   rem;
   logic [Q_W-1:0]   q_fix;
   logic [Q_W-1:0]   q_sgn;
   coord_type        quot_ff;
   coord_type        quot_in;

   // magnitude plus half the divisor gives round to nearest, ties away from zero
   always_comb begin
      mag_in = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
      mag_in = mag_in + SUM_W'(divisor >> 1);
   end

   always_comb begin
      q0      = prod_ff[SUM_W +: Q_W];
      back    = E_W'(q0) * E_W'(cnt_ff);
      rem     = E_W'(mag_ff) - back;
      q_fix   = (rem >= E_W'(cnt_ff)) ? (q0 + Q_W'(1)) : q0;
      q_sgn   = neg_ff ? (Q_W'(0) - q_fix) : q_fix;
      quot_in = q_sgn[COORD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v0_ff <= start;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         mag_ff <= mag_in;
         neg_ff <= dividend[SUM_W-1];
         cnt_ff <= divisor;
         rcp_ff <= recip[divisor];
      end
      if (v0_ff) begin
         prod_ff <= P_W'(mag_ff) * P_W'(rcp_ff);
      end
      if (v1_ff) begin
         quot_ff <= quot_in;
      end
   end

   assign done     = v2_ff;
   assign quotient = quot_ff;

endmodule

`default_nettype wire

@@ design/point_path_boxcar_smoother_top.sv @@
// Centred moving average over a path of 2D points.
// req_ carries one point per item, tlast on the final point of the path.
// rsp_ carries one smoothed point per item, tlast on the final one of the path.
// csr_wr writes the window radius; write it only while the block is idle.
// Results lag the input by the radius; the last point flushes all pending
// results, then the path state clears for the next path.
// Each input item is accepted, checked and then written to the store. For
// every result it releases, the window bounds step one entry at a time, one
// read per step, the last read settles when the window moves, and the mean
// goes through a reciprocal divider. The window sums are kept running in a
// point store with one read port, one read a cycle. With a steady radius one
// item releases one result; a new item is accepted only while idle.
// A result waits in the rsp_ register while the receiver stalls; the next
// result is held back until that register is taken.
// reset clears the radius to 0 and empties the path; store contents are left
// as they are and no entry is read before it is written.
`default_nettype none

module point_path_boxcar_smoother_top #(
   parameter int MAX_RADIUS = 15
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_wr,
   input  wire logic [pps_pkg::CSR_W-1:0]   csr_wdata,   // radius
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [2*pps_pkg::COORD_W-1:0] req_tdata, // x_coord, y_coord
   input  wire logic                        req_tlast,   // last_point
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [2*pps_pkg::COORD_W-1:0]    rsp_tdata,   // x_smooth, y_smooth
   output logic                             rsp_tlast    // path_end
);
   import pps_pkg::*;

   localparam int DEPTH  = 2 * MAX_RADIUS + 1;
   localparam int IDX_W  = $clog2(3 * DEPTH + 1);
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SUM_W  = COORD_W + $clog2(DEPTH);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CHECK  = 3'd1;
   localparam logic [2:0] S_ADJ    = 3'd2;
   localparam logic [2:0] S_DIV    = 3'd3;
   localparam logic [2:0] S_WAIT   = 3'd4;
   localparam logic [2:0] S_FINISH = 3'd5;

   function automatic logic [ADDR_W-1:0] slot(input logic [IDX_W-1:0] v);
      logic [IDX_W-1:0] r;
      if (v >= IDX_W'(2 * DEPTH)) begin
         r = v - IDX_W'(2 * DEPTH);
      end else if (v >= IDX_W'(DEPTH)) begin
         r = v - IDX_W'(DEPTH);
      end else begin
         r = v;
      end
      return r[ADDR_W-1:0];
   endfunction

   logic [2*COORD_W-1:0] mem [DEPTH];

   logic [2:0]           state_ff, state_in;
   logic [CSR_W-1:0]     radius_ff;
   logic [IDX_W-1:0]     recv_ff, recv_in;
   logic [IDX_W-1:0]     emit_ff, emit_in;
   logic [IDX_W-1:0]     lo_ff, lo_in;
   logic [IDX_W-1:0]     hx_ff, hx_in;
   logic [IDX_W-1:0]     tlo_ff, tlo_in;
   logic [IDX_W-1:0]     thx_ff, thx_in;
   logic [IDX_W-1:0]     n_ff, n_in;
   logic signed [SUM_W-1:0] sum_x_ff, sum_x_in;
   logic signed [SUM_W-1:0] sum_y_ff, sum_y_in;
   logic                 pend_ff, pend_in;
   logic                 pend_sub_ff, pend_sub_in;
   logic                 pend_fwd_ff, pend_fwd_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   coord_type            pt_x_ff, pt_x_in;
   coord_type            pt_y_ff, pt_y_in;
   logic                 last_ff, last_in;
   coord_type            rsp_x_ff, rsp_x_in;
   coord_type            rsp_y_ff, rsp_y_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic [2*COORD_W-1:0] rd_q_ff;

   logic [RAD_W-1:0]     rad;
   logic [IDX_W-1:0]     emit_hi;
   logic [IDX_W-1:0]     rd_idx;
   logic                 mem_we;
   logic                 div_start;
   logic                 div_x_done, div_y_done;
   coord_type            div_x_q, div_y_q;
   coord_type            add_x, add_y;
   logic                 req_hs;

   always_comb begin
      if (IDX_W'(radius_ff) > IDX_W'(MAX_RADIUS)) begin
         rad = RAD_W'(MAX_RADIUS);
      end else begin
         rad = RAD_W'(radius_ff);
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign req_hs     = req_tvalid && req_tready;
   assign emit_hi    = emit_ff + IDX_W'(rad);

   always_comb begin
      state_in     = state_ff;
      recv_in      = recv_ff;
      emit_in      = emit_ff;
      lo_in        = lo_ff;
      hx_in        = hx_ff;
      tlo_in       = tlo_ff;
      thx_in       = thx_ff;
      n_in         = n_ff;
      sum_x_in     = sum_x_ff;
      sum_y_in     = sum_y_ff;
      pend_in      = 1'b0;
      pend_sub_in  = pend_sub_ff;
      pend_fwd_in  = pend_fwd_ff;
      rsp_valid_in = rsp_valid_ff;
      pt_x_in      = pt_x_ff;
      pt_y_in      = pt_y_ff;
      last_in      = last_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_last_in  = rsp_last_ff;
      rd_idx       = lo_ff;
      mem_we       = 1'b0;
      div_start    = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // fold in the entry read last cycle; the newest point is not yet in the store
      add_x = pend_fwd_ff ? pt_x_ff : rd_q_ff[COORD_W-1:0];
      add_y = pend_fwd_ff ? pt_y_ff : rd_q_ff[2*COORD_W-1:COORD_W];
      if (pend_ff) begin
         if (pend_sub_ff) begin
            sum_x_in = sum_x_ff - SUM_W'(add_x);
            sum_y_in = sum_y_ff - SUM_W'(add_y);
         end else begin
            sum_x_in = sum_x_ff + SUM_W'(add_x);
            sum_y_in = sum_y_ff + SUM_W'(add_y);
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_hs) begin
               pt_x_in  = req_tdata[COORD_W-1:0];
               pt_y_in  = req_tdata[2*COORD_W-1:COORD_W];
               last_in  = req_tlast;
               n_in     = recv_ff;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if ((emit_ff <= n_ff) && (last_ff || (emit_hi <= n_ff))) begin
               tlo_in   = (emit_ff >= IDX_W'(rad)) ? (emit_ff - IDX_W'(rad)) : '0;
               thx_in   = ((emit_hi <= n_ff) ? emit_hi : n_ff) + IDX_W'(1);
               state_in = S_ADJ;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_ADJ: begin
            // drop old low entries first, before anything else
            priority if (lo_ff < tlo_ff) begin
               rd_idx      = lo_ff;
               pend_in     = 1'b1;
               pend_sub_in = 1'b1;
               lo_in       = lo_ff + IDX_W'(1);
            end else if (hx_ff < thx_ff) begin
               rd_idx      = hx_ff;
               pend_in     = 1'b1;
               pend_sub_in = 1'b0;
               hx_in       = hx_ff + IDX_W'(1);
            end else if (hx_ff > thx_ff) begin
               rd_idx      = hx_ff - IDX_W'(1);
               pend_in     = 1'b1;
               pend_sub_in = 1'b1;
               hx_in       = hx_ff - IDX_W'(1);
            end else if (lo_ff > tlo_ff) begin
               rd_idx      = lo_ff - IDX_W'(1);
               pend_in     = 1'b1;
               pend_sub_in = 1'b0;
               lo_in       = lo_ff - IDX_W'(1);
            end else begin
               if (!pend_ff) begin
                  state_in = S_DIV;
               end
            end
            pend_fwd_in = (rd_idx == n_ff);
         end
         S_DIV: begin
            if (!rsp_valid_ff) begin
               div_start = 1'b1;
               state_in  = S_WAIT;
            end
         end
         S_WAIT: begin
            if (div_x_done && div_y_done) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = div_x_q;
               rsp_y_in     = div_y_q;
               rsp_last_in  = last_ff && (emit_ff == n_ff);
               emit_in      = emit_ff + IDX_W'(1);
               state_in     = S_CHECK;
            end
         end
         S_FINISH: begin
            mem_we   = 1'b1;
            state_in = S_IDLE;
            if (last_ff) begin
               recv_in  = '0;
               emit_in  = '0;
               lo_in    = '0;
               hx_in    = '0;
               sum_x_in = '0;
               sum_y_in = '0;
            end else if (emit_ff >= IDX_W'(2 * DEPTH)) begin
               recv_in = n_ff + IDX_W'(1) - IDX_W'(DEPTH);
               emit_in = emit_ff - IDX_W'(DEPTH);
               lo_in   = lo_ff - IDX_W'(DEPTH);
               hx_in   = hx_ff - IDX_W'(DEPTH);
            end else begin
               recv_in = n_ff + IDX_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         radius_ff    <= '0;
         recv_ff      <= '0;
         emit_ff      <= '0;
         lo_ff        <= '0;
         hx_ff        <= '0;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_wr) begin
            radius_ff <= csr_wdata;
         end
         recv_ff      <= recv_in;
         emit_ff      <= emit_in;
         lo_ff        <= lo_in;
         hx_ff        <= hx_in;
         sum_x_ff     <= sum_x_in;
         sum_y_ff     <= sum_y_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tlo_ff      <= tlo_in;
      thx_ff      <= thx_in;
      n_ff        <= n_in;
      pend_sub_ff <= pend_sub_in;
      pend_fwd_ff <= pend_fwd_in;
      pt_x_ff     <= pt_x_in;
      pt_y_ff     <= pt_y_in;
      last_ff     <= last_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[slot(n_ff)] <= {pt_y_ff, pt_x_ff};
      end
      rd_q_ff <= mem[slot(rd_idx)];
   end

   pps_round_div #(
      .SUM_W   (SUM_W),
      .MAX_CNT (DEPTH),
      .CNT_W   (CNT_W)
   ) u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_x_ff),
      .divisor  (CNT_W'(thx_ff - tlo_ff)),
      .done     (div_x_done),
      .quotient (div_x_q)
   );

   pps_round_div #(
      .SUM_W   (SUM_W),
      .MAX_CNT (DEPTH),
      .CNT_W   (CNT_W)
   ) u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_y_ff),
      .divisor  (CNT_W'(thx_ff - tlo_ff)),
      .done     (div_y_done),
      .quotient (div_y_q)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_y_ff, rsp_x_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire
